### sv/atqa_pkg.sv
// shared types, constants and the task-to-channel map for the adc task queue averager
// no dependencies

package atqa_pkg;

	localparam int TASK_W        = 3;
	localparam int CHAN_W        = 2;
	localparam int RES_W         = 12;
	localparam int READY_W       = 6;
	localparam int TASK_KINDS    = 6;
	localparam int SAMPLE_FIELDS = 8;
	localparam int SMP_IDX_W     = $clog2(SAMPLE_FIELDS);

	localparam logic [TASK_W-1:0] EMPTY_CODE = 3'd7;

	typedef enum logic {
		CMD_QUEUE = 1'b0,
		CMD_DONE  = 1'b1
	} cmd_t;

	typedef enum logic [TASK_W-1:0] {
		TASK_BRIGHT_CTL  = 3'd0,
		TASK_BATT_CTL    = 3'd1,
		TASK_BRIGHT_DISP = 3'd2,
		TASK_BATT_DISP   = 3'd3,
		TASK_CPU_TEMP    = 3'd4,
		TASK_OUT_TEMP    = 3'd5
	} task_t;

	typedef enum logic [CHAN_W-1:0] {
		CHAN_BRIGHT   = 2'd0,
		CHAN_BATT     = 2'd1,
		CHAN_CPU_TEMP = 2'd2,
		CHAN_OUT_TEMP = 2'd3
	} chan_t;

	function automatic logic [CHAN_W-1:0] chan_of_task(input logic [TASK_W-1:0] code);
		logic [CHAN_W-1:0] ch;
		case (code)
			TASK_BRIGHT_CTL:  ch = CHAN_BRIGHT;
			TASK_BATT_CTL:    ch = CHAN_BATT;
			TASK_BRIGHT_DISP: ch = CHAN_BRIGHT;
			TASK_BATT_DISP:   ch = CHAN_BATT;
			TASK_CPU_TEMP:    ch = CHAN_CPU_TEMP;
			TASK_OUT_TEMP:    ch = CHAN_OUT_TEMP;
			default:          ch = CHAN_BRIGHT;
		endcase
		return ch;
	endfunction

endpackage

### sv/atqa_avg.sv
// sample averager: one shared adder accumulates the samples one per cycle, then
// (for a count that is not a power of two) a reciprocal multiply gives the quotient
// depends on atqa_pkg

module atqa_avg import atqa_pkg::*; #(
	parameter int SAMPLE_COUNT = 8,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] smp_in [SAMPLE_FIELDS],
	output logic                   busy,
	output logic [RES_W-1:0]       mean
);

	localparam int SH      = $clog2(SAMPLE_COUNT);
	localparam int SUM_W   = SAMPLE_BITS + SH;
	localparam bit POW2    = (SAMPLE_COUNT & (SAMPLE_COUNT - 1)) == 0;
	localparam int CNT_MAX = (SAMPLE_FIELDS > SAMPLE_COUNT) ? SAMPLE_FIELDS : SAMPLE_COUNT;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam int MW      = (SUM_W > RES_W) ? SUM_W : RES_W;

	// floor(sum / count) as (sum * ceil(2^RCP_SH / count)) >> RCP_SH, exact for any sum
	localparam int RCP_SH  = SUM_W + SH;
	localparam int RCP_W   = SUM_W + 2;
	localparam int PROD_W  = SUM_W + RCP_W;
	localparam longint unsigned RCP =
		((64'd1 << RCP_SH) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
	localparam logic [RCP_W-1:0] RCP_C = RCP_W'(RCP);

	typedef enum logic [1:0] {
		A_IDLE,
		A_ACC,
		A_DIV
	} avg_state_t;

	avg_state_t             state_q;
	logic [SAMPLE_BITS-1:0] smp_q [SAMPLE_FIELDS];
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [RES_W-1:0]       mean_q;

	logic [SAMPLE_BITS-1:0] sel;
	logic [SUM_W-1:0]       add_y;
	logic [SUM_W-1:0]       shr_sum;
	logic [PROD_W-1:0]      prod;
	logic [MW-1:0]          q_ext;
	logic [MW-1:0]          s_ext;

	// shared adder accumulates in A_ACC; the multiply divides in A_DIV
	always_comb begin
		sel = '0;
		if (cnt_q < CNT_W'(SAMPLE_FIELDS)) begin
			sel = smp_q[cnt_q[SMP_IDX_W-1:0]];
		end
		add_y   = sum_q + SUM_W'(sel);
		shr_sum = add_y >> SH;
		prod    = PROD_W'(sum_q) * PROD_W'(RCP_C);
		q_ext   = MW'(prod >> RCP_SH);
		s_ext   = MW'(shr_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			sum_q   <= '0;
			cnt_q   <= '0;
			mean_q  <= '0;
			for (int i = 0; i < SAMPLE_FIELDS; i++) begin
				smp_q[i] <= '0;
			end
		end else begin
			case (state_q)
				A_IDLE: begin
					if (start) begin
						smp_q   <= smp_in;
						// rounding offset goes in first, half rounds up
						sum_q   <= SUM_W'(SAMPLE_COUNT / 2);
						cnt_q   <= '0;
						state_q <= A_ACC;
					end
				end
				A_ACC: begin
					sum_q <= add_y;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SAMPLE_COUNT - 1)) begin
						cnt_q <= '0;
						if (POW2) begin
							mean_q  <= s_ext[RES_W-1:0];
							state_q <= A_IDLE;
						end else begin
							state_q <= A_DIV;
						end
					end
				end
				A_DIV: begin
					mean_q  <= q_ext[RES_W-1:0];
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign busy = (state_q != A_IDLE);
	assign mean = mean_q;

endmodule

### sv/adc_task_queue_averager.sv
// top level of the adc task queue averager: slot ring, head pointer, sticky ready bits,
// sequencer and output register; averaging runs in atqa_avg
// depends on atqa_pkg and atqa_avg
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  in       | in_valid / in_stall | command, task_req, sample_0 .. sample_7
//  out      | out_valid/out_stall | start_valid, start_channel, result_valid,
//           |                     | result_task, result_value, ready_flags,
//           |                     | request_dropped
//
// a request item passes from accept through S_SCAN, where the slot search reads one ring
// slot per cycle, and S_FIN into the output register; an ignored task code goes to S_FIN
// a conversion-done item goes through S_HEAD, S_NEXT and S_AVG, which waits for the shared
// adder taking one sample per cycle and, for a non-power-of-two count, the multiply
// in_stall is high from accept until the result moves into the output register, so the
// next item can be accepted in the cycle after that
// a waiting result in the output register does not block the next accept; the block only
// holds when a second result is ready while the first is still stalled
// reset empties all slots, zeroes the head pointer and the ready bits, and drops the output

module adc_task_queue_averager import atqa_pkg::*; #(
	parameter int SLOT_COUNT   = 4,
	parameter int SAMPLE_COUNT = 8,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic [TASK_W-1:0]      task_req,
	input  logic [SAMPLE_BITS-1:0] sample_0,
	input  logic [SAMPLE_BITS-1:0] sample_1,
	input  logic [SAMPLE_BITS-1:0] sample_2,
	input  logic [SAMPLE_BITS-1:0] sample_3,
	input  logic [SAMPLE_BITS-1:0] sample_4,
	input  logic [SAMPLE_BITS-1:0] sample_5,
	input  logic [SAMPLE_BITS-1:0] sample_6,
	input  logic [SAMPLE_BITS-1:0] sample_7,

	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   start_valid,
	output logic [CHAN_W-1:0]      start_channel,
	output logic                   result_valid,
	output logic [TASK_W-1:0]      result_task,
	output logic [RES_W-1:0]       result_value,
	output logic [READY_W-1:0]     ready_flags,
	output logic                   request_dropped
);

	localparam int PTR_W = $clog2(SLOT_COUNT);

	typedef enum logic [2:0] {
		S_IDLE,  // waiting for an item
		S_SCAN,  // request: walk the ring from the head for an empty slot
		S_HEAD,  // completion: retire the head task, advance the pointer
		S_NEXT,  // completion: start whatever waits in the new head slot
		S_AVG,   // completion: wait for the averager
		S_FIN    // hand the result to the output register
	} state_t;

	state_t              state_q;
	logic [TASK_W-1:0]   slots_q [SLOT_COUNT];
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [PTR_W-1:0]    scan_q;
	logic [READY_W-1:0]  ready_q;
	logic [TASK_W-1:0]   req_q;

	// staged result of the item at work
	logic                sv_q;
	logic [CHAN_W-1:0]   sc_q;
	logic                rv_q;
	logic [TASK_W-1:0]   rt_q;
	logic [RES_W-1:0]    val_q;
	logic                rd_q;

	// output register
	logic                out_valid_q;
	logic                out_sv_q;
	logic [CHAN_W-1:0]   out_sc_q;
	logic                out_rv_q;
	logic [TASK_W-1:0]   out_rt_q;
	logic [RES_W-1:0]    out_val_q;
	logic [READY_W-1:0]  out_ready_q;
	logic                out_rd_q;

	logic                accept;
	logic                out_take;
	logic                avg_start;
	logic                avg_busy;
	logic [RES_W-1:0]    avg_mean;
	logic [SAMPLE_BITS-1:0] smp_in [SAMPLE_FIELDS];
	logic [TASK_W-1:0]   slot_rd;
	logic                slot_full;
	logic [PTR_W-1:0]    ptr_nxt;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign avg_start = accept && (command == CMD_DONE);

	assign smp_in[0] = sample_0;
	assign smp_in[1] = sample_1;
	assign smp_in[2] = sample_2;
	assign smp_in[3] = sample_3;
	assign smp_in[4] = sample_4;
	assign smp_in[5] = sample_5;
	assign smp_in[6] = sample_6;
	assign smp_in[7] = sample_7;

	// single read port on the ring, addressed by the walking pointer
	assign slot_rd   = slots_q[ptr_q];
	assign slot_full = (slot_rd < TASK_W'(TASK_KINDS));
	assign ptr_nxt   = (ptr_q == PTR_W'(SLOT_COUNT - 1)) ? '0 : ptr_q + 1'b1;

	atqa_avg #(
		.SAMPLE_COUNT (SAMPLE_COUNT),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (avg_start),
		.smp_in (smp_in),
		.busy   (avg_busy),
		.mean   (avg_mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			ptr_q       <= '0;
			scan_q      <= '0;
			ready_q     <= '0;
			req_q       <= '0;
			sv_q        <= 1'b0;
			sc_q        <= '0;
			rv_q        <= 1'b0;
			rt_q        <= '0;
			val_q       <= '0;
			rd_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_sv_q    <= 1'b0;
			out_sc_q    <= '0;
			out_rv_q    <= 1'b0;
			out_rt_q    <= '0;
			out_val_q   <= '0;
			out_ready_q <= '0;
			out_rd_q    <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slots_q[i] <= EMPTY_CODE;
			end
		end else begin
			// in S_FIN a taken output is refilled there instead
			if (out_take && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q  <= task_req;
						ptr_q  <= head_q;
						scan_q <= '0;
						sv_q   <= 1'b0;
						sc_q   <= '0;
						rv_q   <= 1'b0;
						rt_q   <= '0;
						val_q  <= '0;
						rd_q   <= 1'b0;
						if (command == CMD_DONE) begin
							state_q <= S_HEAD;
						end else if (task_req < TASK_W'(TASK_KINDS)) begin
							state_q <= S_SCAN;
						end else begin
							// unknown task code: ignored, empty result
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (!slot_full) begin
						slots_q[ptr_q] <= req_q;
						// only a task landing in the head slot starts right away
						if (scan_q == '0) begin
							sv_q <= 1'b1;
							sc_q <= chan_of_task(req_q);
						end
						state_q <= S_FIN;
					end else if (scan_q == PTR_W'(SLOT_COUNT - 1)) begin
						rd_q    <= 1'b1;
						state_q <= S_FIN;
					end else begin
						ptr_q  <= ptr_nxt;
						scan_q <= scan_q + 1'b1;
					end
				end
				S_HEAD: begin
					if (slot_full) begin
						ready_q <= ready_q | (READY_W'(1) << slot_rd);
						rv_q    <= 1'b1;
						rt_q    <= slot_rd;
					end
					// pointer advances even when the head was empty
					slots_q[ptr_q] <= EMPTY_CODE;
					ptr_q          <= ptr_nxt;
					head_q         <= ptr_nxt;
					state_q        <= S_NEXT;
				end
				S_NEXT: begin
					if (slot_full) begin
						sv_q <= 1'b1;
						sc_q <= chan_of_task(slot_rd);
					end
					state_q <= S_AVG;
				end
				S_AVG: begin
					if (!avg_busy) begin
						val_q   <= rv_q ? avg_mean : '0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_sv_q    <= sv_q;
						out_sc_q    <= sc_q;
						out_rv_q    <= rv_q;
						out_rt_q    <= rt_q;
						out_val_q   <= val_q;
						out_ready_q <= ready_q;
						out_rd_q    <= rd_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign start_valid     = out_sv_q;
	assign start_channel   = out_sc_q;
	assign result_valid    = out_rv_q;
	assign result_task     = out_rt_q;
	assign result_value    = out_val_q;
	assign ready_flags     = out_ready_q;
	assign request_dropped = out_rd_q;

	// sticky ready bits never clear
	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((ready_q & $past(ready_q)) == $past(ready_q)))
		else $error("ready bit cleared");

	// the head pointer moves only when a completion retires the head slot
	a_head_moves: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_HEAD |=> head_q == $past(head_q))
		else $error("head pointer moved outside retire step");

	// a dropped request neither starts a conversion nor carries a result
	a_drop_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_rd_q |-> !out_sv_q && !out_rv_q)
		else $error("dropped request with start or result");

	// a delivered result has its task's ready bit set in the same item
	a_result_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_rv_q |-> ((out_ready_q >> out_rt_q) & READY_W'(1)) != '0)
		else $error("result without ready bit");

	// unused result fields read as zero
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_rv_q |-> out_rt_q == '0 && out_val_q == '0)
		else $error("result fields not cleared");

endmodule
